// ----- src/pixel_bin_occupancy_counter_unit_defines.svh -----
// Assertion macros for the pixel bin occupancy counter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PIXEL_BIN_OCCUPANCY_COUNTER_UNIT_DEFINES_SVH
`define PIXEL_BIN_OCCUPANCY_COUNTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock out of reset.
`define PBOC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true out of reset.
`define PBOC_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PBOC_ASSERT(name, prop, msg)
`define PBOC_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ----- src/pboc_pkg.sv -----
// Shared constants and types for the pixel bin occupancy counter.
// No dependencies.
`timescale 1ns / 1ps
package pboc_pkg;

  localparam int VALUE_W = 18;   // Q2.16 channel value
  localparam int FRAC_W  = 16;
  localparam int SH_W    = 5;    // holds FRAC_W
  localparam int OUT_W   = 11;
  localparam int DEPTH_W = 4;
  localparam int NUM_CH  = 3;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [DEPTH_W-1:0] BIT_DEPTH_RESET = 4'd8;

  typedef enum logic [0:0] {
    REG_BIT_DEPTH = 1'b0
  } reg_idx_e;

endpackage

// ----- src/pboc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module pboc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/pboc_binner.sv -----
// Maps one Q2.16 channel value to a histogram bin index.
// Depends on pboc_pkg.
`timescale 1ns / 1ps
module pboc_binner
  import pboc_pkg::*;
#(
  parameter int MAX_BIT_DEPTH = 10
) (
  input  logic signed [VALUE_W-1:0]               value_i,
  input  logic [$clog2(MAX_BIT_DEPTH+1)-1:0]      depth_i,
  output logic                                    hit_o,
  output logic [MAX_BIT_DEPTH-1:0]                bin_o
);

  logic [SH_W-1:0]   shamt;
  logic [FRAC_W-1:0] shifted;

  // Values of 1.0 and above touch no bin; negatives fold into bin 0.
  assign hit_o   = !(!value_i[VALUE_W-1] && value_i[FRAC_W]);
  assign shamt   = SH_W'(FRAC_W) - SH_W'(depth_i);
  assign shifted = value_i[FRAC_W-1:0] >> shamt;
  assign bin_o   = value_i[VALUE_W-1] ? '0 : shifted[MAX_BIT_DEPTH-1:0];

endmodule

// ----- src/pixel_bin_occupancy_counter_unit.sv -----
// Pixel bin occupancy counter: input register stage, then output register, from
// input word to result word; throughput one pixel per cycle when not stalled.
// Input stalls while a last-pixel word waits on a full, unread result register.
// Bitmap lives in a 3x3 bank of 1W1R RAMs (each channel writes one bank per reader).
// Reset: control cleared, bit_depth = 8, then a clearing pass over the bitmap
// with in_ready_o low; every bit_depth write restarts it.
`include "pixel_bin_occupancy_counter_unit_defines.svh"
`timescale 1ns / 1ps
module pixel_bin_occupancy_counter_unit
  import pboc_pkg::*;
#(
  parameter int MAX_BIT_DEPTH = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB-style configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  // pixel input
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] red_value_i,
  input  logic signed [VALUE_W-1:0] green_value_i,
  input  logic signed [VALUE_W-1:0] blue_value_i,
  input  logic                      last_pixel_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [OUT_W-1:0]          occupied_bins_o
);

  localparam int BIN_SLOTS = 1 << MAX_BIT_DEPTH;
  localparam int AW        = MAX_BIT_DEPTH;
  localparam int ACT_W     = $clog2(MAX_BIT_DEPTH + 1);
  localparam int CNT_W     = MAX_BIT_DEPTH + 1;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic               cfg_wr;
  logic               bd_we;
  logic [DEPTH_W-1:0] bit_depth_q;
  logic [ACT_W-1:0]   act_depth;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    bd_we  = 1'b0;
    prdata = '0;
    unique case (reg_idx_e'(paddr[APB_AW-1:2]))
      REG_BIT_DEPTH: begin
        bd_we  = cfg_wr;
        prdata = APB_DW'(bit_depth_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_depth_q <= BIT_DEPTH_RESET;
    end else if (bd_we) begin
      bit_depth_q <= pwdata[DEPTH_W-1:0];
    end
  end

  // out-of-range depths clamp to 1..MAX_BIT_DEPTH
  always_comb begin
    if (bit_depth_q == '0) begin
      act_depth = ACT_W'(1);
    end else if (int'(bit_depth_q) > MAX_BIT_DEPTH) begin
      act_depth = ACT_W'(MAX_BIT_DEPTH);
    end else begin
      act_depth = ACT_W'(bit_depth_q);
    end
  end

  // ---------------------------------------------------------------------
  // Clearing sweep
  // ---------------------------------------------------------------------
  logic          clr_active_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (bd_we) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == {AW{1'b1}}) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Bin lookup on the incoming word
  // ---------------------------------------------------------------------
  logic signed [VALUE_W-1:0] ch_value [NUM_CH];
  logic [NUM_CH-1:0]         in_hit;
  logic [AW-1:0]             in_bin [NUM_CH];

  assign ch_value[0] = red_value_i;
  assign ch_value[1] = green_value_i;
  assign ch_value[2] = blue_value_i;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_bin
    pboc_binner #(.MAX_BIT_DEPTH(MAX_BIT_DEPTH)) u_binner (
      .value_i (ch_value[c]),
      .depth_i (act_depth),
      .hit_o   (in_hit[c]),
      .bin_o   (in_bin[c])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 1: registered word plus bitmap read data
  // ---------------------------------------------------------------------
  logic              s1_valid_q;
  logic              s1_last_q;
  logic [NUM_CH-1:0] s1_hit_q;
  logic [AW-1:0]     s1_bin_q [NUM_CH];
  logic              s1_stall;
  logic              s1_fire;
  logic              in_fire;

  // a last-pixel word waits here only while the result register is full
  assign s1_stall   = s1_valid_q && s1_last_q && out_valid_o && !out_ready_i;
  assign s1_fire    = s1_valid_q && !s1_stall;
  assign in_ready_o = !clr_active_q && !s1_stall;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q <= last_pixel_i;
      s1_hit_q  <= in_hit;
      s1_bin_q  <= in_bin;
    end
  end

  // Bitmap banks: bank [c][w] holds bits set by channel w, read for channel c.
  // A bin is occupied if any of the three banks read for c has it set.
  logic [NUM_CH-1:0] rd_bits [NUM_CH];
  logic [AW-1:0]     rd_addr [NUM_CH];
  logic [NUM_CH-1:0] ram_we;
  logic [AW-1:0]     ram_waddr [NUM_CH];
  logic [NUM_CH-1:0] ram_wdata;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      // a stalled word re-reads its own bins so its data stays current
      rd_addr[c]   = s1_stall ? s1_bin_q[c] : in_bin[c];
      ram_we[c]    = clr_active_q || (s1_fire && s1_hit_q[c]);
      ram_waddr[c] = clr_active_q ? clr_cnt_q : s1_bin_q[c];
      ram_wdata[c] = !clr_active_q;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_rd
    for (genvar w = 0; w < NUM_CH; w++) begin : g_wr
      pboc_ram #(.WIDTH(1), .DEPTH(BIN_SLOTS)) u_ram (
        .clk_i   (clk_i),
        .we_i    (ram_we[w]),
        .waddr_i (ram_waddr[w]),
        .wdata_i (ram_wdata[w]),
        .raddr_i (rd_addr[c]),
        .rdata_o (rd_bits[c][w])
      );
    end
  end

  // Forwarding of the word that wrote at the previous edge (RAM read missed it).
  logic [NUM_CH-1:0] fwd_hit_q;
  logic [AW-1:0]     fwd_bin_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= '0;
    end else if (s1_fire && !bd_we) begin
      fwd_hit_q <= s1_hit_q;
    end else begin
      fwd_hit_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      fwd_bin_q <= s1_bin_q;
    end
  end

  // New bins in this pixel: not in bitmap, not just written, not a repeat.
  logic [NUM_CH-1:0] new_bin;
  logic [1:0]        add_cnt;

  always_comb begin
    add_cnt = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      new_bin[c] = s1_hit_q[c] && !(|rd_bits[c]);
      for (int w = 0; w < NUM_CH; w++) begin
        if (fwd_hit_q[w] && (fwd_bin_q[w] == s1_bin_q[c])) begin
          new_bin[c] = 1'b0;
        end
      end
      for (int j = 0; j < c; j++) begin
        if (s1_hit_q[j] && (s1_bin_q[j] == s1_bin_q[c])) begin
          new_bin[c] = 1'b0;
        end
      end
      add_cnt = add_cnt + 2'(new_bin[c]);
    end
  end

  // ---------------------------------------------------------------------
  // Running count and result register
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] occ_total_q;
  logic [CNT_W-1:0] occ_total_d;
  logic             out_valid_q;
  logic [OUT_W-1:0] occ_out_q;

  assign occ_total_d = occ_total_q + CNT_W'(add_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_total_q <= '0;
    end else if (bd_we) begin
      occ_total_q <= '0;
    end else if (s1_fire) begin
      occ_total_q <= occ_total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      occ_out_q <= OUT_W'(occ_total_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign occupied_bins_o = occ_out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `PBOC_ASSERT(a_total_bounded, (occ_total_q <= (CNT_W'(1) << act_depth)), "count exceeds bins")
  `PBOC_ASSERT(a_last_gives_result, (s1_fire && s1_last_q) |=> out_valid_q, "result lost")
  `PBOC_ASSERT(a_cfg_clears, bd_we |=> (clr_active_q && (occ_total_q == '0)), "clear missed")
  `PBOC_ASSERT_NEVER(a_no_work_in_clear, clr_active_q && s1_fire && !$past(bd_we), "word in clear")

endmodule
